@@ sv/pfla_pkg.sv @@
// Shared constants and codes for the paged free-list allocator.
package pfla_pkg;

  // Link store geometry: one entry per block index
  localparam int STORE_DEPTH = 1024;
  localparam int IDX_W       = 10;
  localparam int LINK_W      = 11;
  localparam logic [LINK_W-1:0] NIL_LINK = 11'd1024;

  // Field widths
  localparam int MODE_W   = 2;
  localparam int STATUS_W = 2;
  localparam int BSIZE_W  = 13;
  localparam int OFF_W    = 22;

  // Request modes
  localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_ALLOCATED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd2;

  // Block size after reset
  localparam logic [BSIZE_W-1:0] BSIZE_RESET = 13'd64;

endpackage

@@ sv/pfla_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module pfla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ sv/paged_free_list_allocator.sv @@
// Paged free-list block allocator: top level.
//
// Hands out fixed-size blocks from a LIFO free list held in a 1024-entry
// next-pointer RAM. Each input word is a request (allocate, free or clear
// all, kind on in_tuser); each of the first three gives one result word with
// a status on out_tuser and the block index and its byte offset (index times
// the block size, low 22 bits) on out_tdata. Mode 3 is taken and dropped
// without a result. A request that answers at once (free, clear,
// or an allocate that finds no page left) is held in the pending slot, and
// the input is ready again once its result has passed from the pending slot
// to the output register. An allocate from a non-empty list goes through
// S_POP first, since the pop waits on the registered RAM read of the head's
// link. An allocate that finds the list empty opens a fresh page: slot 0 is
// handed out, then the links of the page's other slots are written into
// the RAM, one entry per cycle, and no request is taken meanwhile. One result
// can wait in the output register while the next request is taken; a second
// waiting result holds the input off. The user must write the block size
// through cfg_we/cfg_wdata only while nothing is in flight; the block itself
// does not enforce it.
module paged_free_list_allocator
  import pfla_pkg::*;
#(
  parameter int PAGE_BLOCKS = 64,
  parameter int MAX_PAGES   = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // request stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [9:0] block_index
  input  logic [1:0]  in_tuser,   // [1:0] mode
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [9:0] given_index, [31:10] byte_offset
  output logic [1:0]  out_tuser,  // [1:0] status
  // block size register
  input  logic        cfg_we,
  input  logic [12:0] cfg_wdata
);

  localparam int PAGE_FIT   = STORE_DEPTH / PAGE_BLOCKS;
  localparam int PAGE_LIMIT = (MAX_PAGES < PAGE_FIT) ? MAX_PAGES : PAGE_FIT;
  localparam int PG_W       = $clog2(PAGE_LIMIT + 1);
  localparam logic [PG_W-1:0]   PAGE_LIMIT_L = PG_W'(PAGE_LIMIT);
  localparam logic [LINK_W-1:0] BPP_L        = LINK_W'(PAGE_BLOCKS);

  // sequencer states
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_POP   = 2'd1;
  localparam logic [1:0] S_SWEEP = 2'd2;

  logic [1:0]         state_r, state_nxt;
  logic [LINK_W-1:0]  head_r, head_nxt;
  logic [PG_W-1:0]    pages_r, pages_nxt;
  logic [LINK_W-1:0]  base_r, base_nxt;
  logic [IDX_W-1:0]   sweep_r, sweep_nxt;
  logic [IDX_W-1:0]   given_r, given_nxt;
  logic [BSIZE_W-1:0] bsize_r;

  // pending result slot and output register
  logic                pend_valid_r, pend_valid_nxt;
  logic [STATUS_W-1:0] pend_status_r, pend_status_nxt;
  logic [IDX_W-1:0]    pend_idx_r, pend_idx_nxt;
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [IDX_W-1:0]    out_idx_r;
  logic [OFF_W-1:0]    out_off_r;

  // RAM port signals
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [LINK_W-1:0] ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  logic [LINK_W-1:0] ram_rdata;

  logic [MODE_W-1:0] in_mode;
  logic [IDX_W-1:0]  in_index;
  logic              in_acc;
  logic              move;
  logic              exhausted;
  logic [LINK_W-1:0] sweep_next_link;
  logic [IDX_W+BSIZE_W-1:0] product;

  assign in_mode  = in_tuser;
  assign in_index = in_tdata[9:0];
  assign in_tready = (state_r == S_IDLE) && !pend_valid_r;
  assign in_acc    = in_tvalid && in_tready;
  assign move      = pend_valid_r && (!out_valid_r || out_tready);
  assign exhausted = (pages_r >= PAGE_LIMIT_L);
  assign sweep_next_link = {1'b0, sweep_r} + 1'b1;

  pfla_ram #(
    .WIDTH (LINK_W),
    .DEPTH (STORE_DEPTH)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // request sequencer: pop, push, clear and page link sweep
  always_comb begin
    state_nxt       = state_r;
    head_nxt        = head_r;
    pages_nxt       = pages_r;
    base_nxt        = base_r;
    sweep_nxt       = sweep_r;
    given_nxt       = given_r;
    pend_valid_nxt  = pend_valid_r && !move;
    pend_status_nxt = pend_status_r;
    pend_idx_nxt    = pend_idx_r;
    ram_we          = 1'b0;
    ram_waddr       = in_index;
    ram_wdata       = head_r;
    ram_raddr       = head_r[IDX_W-1:0];
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          priority if (in_mode == MODE_ALLOC) begin
            pend_valid_nxt = 1'b1;
            if (!head_r[IDX_W]) begin
              // pop: fetch head's link, finish next cycle
              given_nxt      = head_r[IDX_W-1:0];
              pend_valid_nxt = 1'b0;
              state_nxt      = S_POP;
            end else if (exhausted) begin
              pend_status_nxt = ST_EXHAUSTED;
              pend_idx_nxt    = '0;
            end else begin
              // open a page: hand out slot 0, link the rest
              pend_status_nxt = ST_ALLOCATED;
              pend_idx_nxt    = base_r[IDX_W-1:0];
              head_nxt        = base_r + 1'b1;
              sweep_nxt       = base_r[IDX_W-1:0] + 1'b1;
              base_nxt        = base_r + BPP_L;
              pages_nxt       = pages_r + 1'b1;
              state_nxt       = S_SWEEP;
            end
          end else if (in_mode == MODE_FREE) begin
            ram_we          = 1'b1;
            head_nxt        = {1'b0, in_index};
            pend_valid_nxt  = 1'b1;
            pend_status_nxt = ST_DONE;
            pend_idx_nxt    = '0;
          end else if (in_mode == MODE_CLEAR) begin
            head_nxt        = NIL_LINK;
            pages_nxt       = '0;
            base_nxt        = '0;
            pend_valid_nxt  = 1'b1;
            pend_status_nxt = ST_DONE;
            pend_idx_nxt    = '0;
          end else begin
            // unused mode: dropped
            pend_valid_nxt = pend_valid_r && !move;
          end
        end
      end
      S_POP: begin
        head_nxt        = ram_rdata[IDX_W] ? NIL_LINK : ram_rdata;
        pend_valid_nxt  = 1'b1;
        pend_status_nxt = ST_ALLOCATED;
        pend_idx_nxt    = given_r;
        state_nxt       = S_IDLE;
      end
      S_SWEEP: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_r;
        if (sweep_next_link == base_r) begin
          ram_wdata = NIL_LINK;
          state_nxt = S_IDLE;
        end else begin
          ram_wdata = sweep_next_link;
        end
        sweep_nxt = sweep_r + 1'b1;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign product = pend_idx_r * bsize_r;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      head_r       <= NIL_LINK;
      pages_r      <= '0;
      base_r       <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      bsize_r      <= BSIZE_RESET;
    end else begin
      state_r      <= state_nxt;
      head_r       <= head_nxt;
      pages_r      <= pages_nxt;
      base_r       <= base_nxt;
      pend_valid_r <= pend_valid_nxt;
      if (move) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        bsize_r <= cfg_wdata;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    sweep_r       <= sweep_nxt;
    given_r       <= given_nxt;
    pend_status_r <= pend_status_nxt;
    pend_idx_r    <= pend_idx_nxt;
    if (move) begin
      out_status_r <= pend_status_r;
      out_idx_r    <= pend_idx_r;
      out_off_r    <= product[OFF_W-1:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_off_r, out_idx_r};
  assign out_tuser  = out_status_r;

  // checks
  a_head_nil: assert property (@(posedge clk) disable iff (!rst_n)
    head_r[IDX_W] |-> (head_r[IDX_W-1:0] == '0))
    else $error("list head out of range");

  a_pages_limit: assert property (@(posedge clk) disable iff (!rst_n)
    pages_r <= PAGE_LIMIT_L)
    else $error("page count passed its limit");

  a_pop_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_mode == MODE_ALLOC) && !head_r[IDX_W]) |=> (state_r == S_POP))
    else $error("pop did not wait for link read");

  a_exh_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == ST_EXHAUSTED)) |-> (out_idx_r == '0))
    else $error("exhausted result carries an index");

endmodule
